// ----- design/lhf_pkg.sv -----
// Shared constants and types for the luma half-pel six-tap filter.
// No dependencies; used by the interfaces, the tap lane and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lhf_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned OFF_W      = 2;
  localparam int unsigned LANES      = 4;
  localparam int unsigned TAPS       = 6;
  localparam int unsigned WIN_PIX    = LANES + TAPS - 1;
  localparam int unsigned IN_PIX     = 12;
  localparam int unsigned PAIR_W     = PIX_W + 1;
  // -2534 .. 10726 after rounding, fits comfortably in 16 signed bits
  localparam int unsigned SUM_W      = 16;

  localparam int unsigned TAP_BIG    = 20;
  localparam int unsigned TAP_SMALL  = 5;
  localparam int unsigned ROUND_ADD  = 16;
  localparam int unsigned NORM_SHIFT = 5;
  localparam int unsigned PIX_MAX    = 255;

  typedef logic [PIX_W-1:0]               pix_t;
  typedef logic [TAPS-1:0][PIX_W-1:0]     tap_win_t;
  typedef logic [WIN_PIX-1:0][PIX_W-1:0]  win_t;
  typedef logic [IN_PIX-1:0][PIX_W-1:0]   pix_row_t;
  typedef logic [PAIR_W-1:0]              pair_t;
  typedef logic signed [SUM_W-1:0]        sum_t;

endpackage

`default_nettype wire

// ----- design/lhf_if.sv -----
// Valid/ready channel interfaces for the filter: pixel words in, packed pixels out.
// Depends on lhf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lhf_in_if;
  logic                            valid;
  logic                            ready;
  logic [lhf_pkg::WORD_W-1:0]      word0;
  logic [lhf_pkg::WORD_W-1:0]      word1;
  logic [lhf_pkg::WORD_W-1:0]      word2;
  logic [lhf_pkg::OFF_W-1:0]       byte_offset;

  modport source (output valid, word0, word1, word2, byte_offset, input ready);
  modport sink   (input valid, word0, word1, word2, byte_offset, output ready);
endinterface

interface lhf_out_if;
  logic                            valid;
  logic                            ready;
  logic [lhf_pkg::WORD_W-1:0]      packed_pixels;

  modport source (output valid, packed_pixels, input ready);
  modport sink   (input valid, packed_pixels, output ready);
endinterface

`default_nettype wire

// ----- design/lhf_lane.sv -----
// One output pixel of the six-tap filter: pair sums, weighted sum, clip.
// Two internal register stages; the clip is combinational off the sum register.
// Depends on lhf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lhf_lane (
  input  logic              clk,
  input  logic              adv,
  input  lhf_pkg::tap_win_t win,
  output lhf_pkg::pix_t     pix
);

  lhf_pkg::pair_t outer_r, mid_r, inner_r;
  lhf_pkg::pair_t outer_nxt, mid_nxt, inner_nxt;
  lhf_pkg::sum_t  acc_r, acc_nxt;
  lhf_pkg::sum_t  shf;

  // symmetric kernel: fold the window into three pair sums
  always_comb begin
    outer_nxt = lhf_pkg::PAIR_W'(win[0]) + lhf_pkg::PAIR_W'(win[5]);
    mid_nxt   = lhf_pkg::PAIR_W'(win[1]) + lhf_pkg::PAIR_W'(win[4]);
    inner_nxt = lhf_pkg::PAIR_W'(win[2]) + lhf_pkg::PAIR_W'(win[3]);
  end

  // 20 = 16 + 4, 5 = 4 + 1
  always_comb begin
    acc_nxt = lhf_pkg::SUM_W'(outer_r)
            + lhf_pkg::SUM_W'(lhf_pkg::ROUND_ADD)
            + (lhf_pkg::SUM_W'(inner_r) << 4)
            + (lhf_pkg::SUM_W'(inner_r) << 2)
            - (lhf_pkg::SUM_W'(mid_r) << 2)
            - lhf_pkg::SUM_W'(mid_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outer_r <= outer_nxt;
      mid_r   <= mid_nxt;
      inner_r <= inner_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_comb begin
    shf = acc_r >>> lhf_pkg::NORM_SHIFT;
    if (acc_r[lhf_pkg::SUM_W-1]) begin
      pix = '0;
    end else if (shf > lhf_pkg::SUM_W'(lhf_pkg::PIX_MAX)) begin
      pix = lhf_pkg::PIX_W'(lhf_pkg::PIX_MAX);
    end else begin
      pix = shf[lhf_pkg::PIX_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/luma_halfpel_6tap_filter_x4_unit.sv -----
// Top level of the four-pixel luma half-pel six-tap interpolator.
// Depends on lhf_pkg, lhf_in_if / lhf_out_if and lhf_lane.
`timescale 1ns / 1ps
`default_nettype none

// Takes twelve 8-bit reference pixels packed big-endian in three words plus a
// start offset of 0..3, and returns four horizontally filtered half-pel pixels
// (taps 1,-5,20,20,-5,1, round by 16, shift right 5, clip to 0..255) packed in
// one word, first pixel in the top byte. One beat in per cycle, one beat out
// per cycle while the sink is ready. Pipeline: window select, pair sums,
// weighted sum, then the clip feeding the output register. The whole pipe
// stalls together only when the output register holds a beat the sink has
// not taken, so nothing is lost or repeated; while that beat waits the input
// is held off as well.
module luma_halfpel_6tap_filter_x4_unit (
  input  logic      clk,
  input  logic      rst_n,
  lhf_in_if.sink    in_if,
  lhf_out_if.source out_if
);

  logic                           adv;
  logic                           v1_r, v2_r, v3_r, out_valid_r;
  logic                           v1_nxt, v2_nxt, v3_nxt, out_valid_nxt;
  lhf_pkg::pix_row_t              row;
  lhf_pkg::win_t                  win_r, win_nxt;
  lhf_pkg::pix_t                  lane_pix [lhf_pkg::LANES];
  logic [lhf_pkg::WORD_W-1:0]     out_data_r, out_data_nxt;

  // pipe moves whenever the output register is free or being drained
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;

  // pixel i of the row; pixel 0 is the top byte of word0
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      row[i]     = in_if.word0[lhf_pkg::WORD_W-1-8*i -: lhf_pkg::PIX_W];
      row[i + 4] = in_if.word1[lhf_pkg::WORD_W-1-8*i -: lhf_pkg::PIX_W];
      row[i + 8] = in_if.word2[lhf_pkg::WORD_W-1-8*i -: lhf_pkg::PIX_W];
    end
  end

  // stage 1: nine-pixel window starting at the offset
  always_comb begin
    for (int j = 0; j < int'(lhf_pkg::WIN_PIX); j++) begin
      win_nxt[j] = row[4'(j) + {2'b00, in_if.byte_offset}];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_r <= win_nxt;
    end
  end

  // stages 2 and 3 live in the lanes; lane k sees window pixels k..k+5
  for (genvar k = 0; k < lhf_pkg::LANES; k++) begin : g_lane
    lhf_lane u_lane (
      .clk (clk),
      .adv (adv),
      .win (win_r[k +: lhf_pkg::TAPS]),
      .pix (lane_pix[k])
    );
  end

  // stage 4: output register, lane 0 in the top byte
  always_comb begin
    for (int k = 0; k < int'(lhf_pkg::LANES); k++) begin
      out_data_nxt[lhf_pkg::WORD_W-1-8*k -: lhf_pkg::PIX_W] = lane_pix[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // valid bits travel with the data
  assign v1_nxt        = adv ? in_if.valid : v1_r;
  assign v2_nxt        = adv ? v1_r        : v2_r;
  assign v3_nxt        = adv ? v2_r        : v3_r;
  assign out_valid_nxt = adv ? v3_r        : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.packed_pixels = out_data_r;

`ifndef NO_ASSERTIONS
  // a stall freezes every valid bit in the pipe
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v1_r) && $stable(v2_r) && $stable(v3_r))
    else $error("pipe moved during a stall");

  // an accepted beat always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> v1_r)
    else $error("accepted beat lost at stage 1");

  // a new output beat only comes from a valid stage 3
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !v3_r |=> !out_valid_r)
    else $error("output valid without a stage 3 beat");
`endif

endmodule

`default_nettype wire
